[rtl/utf8ec_pkg.sv]
`default_nettype none

package utf8ec_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 32;
   localparam int unsigned TailWidth  = 2;
   localparam int unsigned IncWidth   = 3;
   // byte_error, tail_errors and error_count, padded to whole bytes
   localparam int unsigned RspWidth   = 40;

   localparam logic [ByteWidth-1:0] ContLow    = 8'h80;
   localparam logic [ByteWidth-1:0] Lead2Low   = 8'hC0;
   localparam logic [ByteWidth-1:0] Lead3Low   = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead4Low   = 8'hF0;
   localparam logic [ByteWidth-1:0] AfterE0Min = 8'hA0;
   localparam logic [ByteWidth-1:0] SurrLead   = 8'hED;
   localparam logic [ByteWidth-1:0] AfterEDMax = 8'h9F;
   localparam logic [ByteWidth-1:0] AfterF0Min = 8'h90;
   localparam logic [ByteWidth-1:0] TopLead    = 8'hF4;
   localparam logic [ByteWidth-1:0] AfterF4Max = 8'h8F;
   localparam logic [ByteWidth-1:0] OverLongHi = 8'hC1;
   localparam logic [ByteWidth-1:0] BadLeadLow = 8'hF5;

   localparam logic [CountWidth-1:0] CountMax = '1;

   typedef struct packed {
      logic                 byte_error;
      logic [TailWidth-1:0] tail_errors;
   } check_result_type;

   // Check one byte against the three bytes before it
   function automatic logic check_byte(input logic [ByteWidth-1:0] cur,
                                       input logic [ByteWidth-1:0] p1,
                                       input logic [ByteWidth-1:0] p2,
                                       input logic [ByteWidth-1:0] p3);
      logic is_cont;
      logic need_cont;
      logic bad;
      is_cont   = (cur >= ContLow) && (cur < Lead2Low);
      need_cont = (p1 >= Lead2Low) || (p2 >= Lead3Low) || (p3 >= Lead4Low);
      bad       = (is_cont != need_cont);
      if ((p1 == Lead3Low) && (cur < AfterE0Min)) bad = 1'b1;
      if ((p1 == SurrLead) && (cur > AfterEDMax)) bad = 1'b1;
      if ((p1 == Lead4Low) && (cur < AfterF0Min)) bad = 1'b1;
      if ((p1 == TopLead) && (cur > AfterF4Max)) bad = 1'b1;
      if ((cur == Lead2Low) || (cur == OverLongHi) || (cur >= BadLeadLow)) bad = 1'b1;
      return bad;
   endfunction

endpackage

`default_nettype wire

[rtl/utf8_stream_error_counter_core.sv]
// UTF-8 stream checker: one byte enters per transaction on the req_ channel
// (req_tlast marks the final byte of a stream) and one result leaves per byte
// on the rsp_ channel, with a per-byte error flag, the count of continuations
// still missing after the final byte, and the running saturating error count.
// The block takes one byte every clock unless a result waits on rsp_tready.
// The input register captures each accepted byte, and the combinational rule
// check and count update then load the result register once it is free.
// While a result waits on rsp_tready the held byte stays put and req_tready
// drops. After the final byte the history and the count restart from zero
// for the next stream.
`default_nettype none

module utf8_stream_error_counter_core
   import utf8ec_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] data_byte
   input  wire logic                req_tlast,   // end_of_stream
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspWidth-1:0]      rsp_tdata    // [0] byte_error, [2:1] tail_errors,
                                                 // [34:3] error_count, [39:35] zero
);

   logic                  in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  in_last_ff;
   logic [ByteWidth-1:0]  hist0_ff, hist0_in;
   logic [ByteWidth-1:0]  hist1_ff, hist1_in;
   logic [ByteWidth-1:0]  hist2_ff, hist2_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_error_ff;
   logic [TailWidth-1:0]  out_tail_ff;
   logic [CountWidth-1:0] out_count_ff;
   logic [CountWidth-1:0] new_count;
   logic [CountWidth:0]   sum;
   logic [IncWidth-1:0]   inc;
   logic                  advance;
   check_result_type      chk;

   // Move the held byte into the result register when that register frees up
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   utf8ec_check u_check (
      .cur_byte  (in_byte_ff),
      .last_byte (in_last_ff),
      .hist0     (hist0_ff),
      .hist1     (hist1_ff),
      .hist2     (hist2_ff),
      .result    (chk)
   );

   // Add this byte's errors and tail errors, saturate at the top
   always_comb begin
      inc = IncWidth'({2'b00, chk.byte_error}) + IncWidth'({1'b0, chk.tail_errors});
      sum = {1'b0, count_ff} + {{(CountWidth+1-IncWidth){1'b0}}, inc};
      new_count = sum[CountWidth] ? CountMax : sum[CountWidth-1:0];
   end

   // Shift history and update the count, or clear both after the final byte
   always_comb begin
      hist0_in = hist0_ff;
      hist1_in = hist1_ff;
      hist2_in = hist2_ff;
      count_in = count_ff;
      if (advance) begin
         if (in_last_ff) begin
            hist0_in = '0;
            hist1_in = '0;
            hist2_in = '0;
            count_in = '0;
         end else begin
            hist0_in = in_byte_ff;
            hist1_in = hist0_ff;
            hist2_in = hist1_ff;
            count_in = new_count;
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hist0_ff     <= '0;
         hist1_ff     <= '0;
         hist2_ff     <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         hist0_ff     <= hist0_in;
         hist1_ff     <= hist1_in;
         hist2_ff     <= hist2_in;
         count_ff     <= count_in;
      end
   end

   // Capture the input transaction
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_error_ff <= chk.byte_error;
         out_tail_ff  <= chk.tail_errors;
         out_count_ff <= new_count;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspWidth-CountWidth-TailWidth-1){1'b0}},
                        out_count_ff, out_tail_ff, out_error_ff};

endmodule

`default_nettype wire

[rtl/utf8ec_check.sv]
`default_nettype none

module utf8ec_check
   import utf8ec_pkg::*;
(
   input  wire logic [ByteWidth-1:0] cur_byte,
   input  wire logic                 last_byte,
   input  wire logic [ByteWidth-1:0] hist0,
   input  wire logic [ByteWidth-1:0] hist1,
   input  wire logic [ByteWidth-1:0] hist2,
   output check_result_type          result
);

   logic tail1;
   logic tail2;
   logic tail3;

   // A zero byte after the stream fails exactly when a continuation is still owed
   always_comb begin
      tail1 = (cur_byte >= Lead2Low) || (hist0 >= Lead3Low) || (hist1 >= Lead4Low);
      tail2 = (cur_byte >= Lead3Low) || (hist0 >= Lead4Low);
      tail3 = (cur_byte >= Lead4Low);
   end

   always_comb begin
      result.byte_error = check_byte(cur_byte, hist0, hist1, hist2);
      if (last_byte) begin
         result.tail_errors = TailWidth'({1'b0, tail1}) + TailWidth'({1'b0, tail2})
                            + TailWidth'({1'b0, tail3});
      end else begin
         result.tail_errors = '0;
      end
   end

endmodule

`default_nettype wire

[tb/utf8_stream_error_counter_core_tb.sv]
`timescale 1ns / 100ps

module utf8_stream_error_counter_core_tb;
   import utf8ec_pkg::*;

   localparam int unsigned RandomBytes = 1525;
   localparam int unsigned QuietTail   = 150;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned DrainCycles = 6;
   localparam int unsigned DirRows     = 25;

   // One result as it leaves on rsp_tdata, most significant field first
   typedef struct packed {
      logic [RspWidth-CountWidth-TailWidth-2:0] pad;
      logic [CountWidth-1:0]                    error_count;
      logic [TailWidth-1:0]                     tail_errors;
      logic                                     byte_error;
   } utf8_result_type;

   // One stimulus row; typed rows carry their own expected result
   typedef struct packed {
      logic [ByteWidth-1:0]  data;
      logic                  eos;
      logic                  typed;
      logic                  byte_error;
      logic [TailWidth-1:0]  tail_errors;
      logic [CountWidth-1:0] error_count;
   } byte_row_type;

   // Directed rows: data, end of stream, typed, byte error, tail errors, count
   localparam byte_row_type DirectedRows [DirRows] = '{
      {8'h00, 1'b1, 1'b1, 1'b0, 2'd0, 32'd0},  // zero byte alone
      {8'hFF, 1'b1, 1'b1, 1'b1, 2'd3, 32'd4},  // top byte, three missing tails
      {8'h80, 1'b1, 1'b1, 1'b1, 2'd0, 32'd1},  // stray continuation
      {8'hC0, 1'b0, 1'b1, 1'b1, 2'd0, 32'd1},  // overlong lead
      {8'hAF, 1'b1, 1'b1, 1'b0, 2'd0, 32'd1},  // continuation it asked for
      {8'hE0, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},  // E0 then a low second byte
      {8'h80, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'h80, 1'b1, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'hE0, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},  // E0 at its lowest legal second byte
      {8'hA0, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'h80, 1'b1, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'hED, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},  // surrogate range after ED
      {8'hA0, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'h80, 1'b1, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'hF0, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},  // overlong four-byte form after F0
      {8'h8F, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'h80, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'h80, 1'b1, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'hF4, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},  // beyond the code space after F4
      {8'h90, 1'b1, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'hC1, 1'b1, 1'b1, 1'b1, 2'd1, 32'd2},  // overlong lead, one tail missing
      {8'hF5, 1'b1, 1'b1, 1'b1, 2'd3, 32'd4},  // lowest forbidden lead
      {8'hE2, 1'b0, 1'b0, 1'b0, 2'd0, 32'd0},  // stream cut inside a character
      {8'h82, 1'b1, 1'b0, 1'b0, 2'd0, 32'd0},
      {8'h7F, 1'b1, 1'b1, 1'b0, 2'd0, 32'd0}   // highest ASCII byte
   };

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;   // [7:0] data_byte
   logic                req_tlast;   // end_of_stream
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspWidth-1:0] rsp_tdata;   // [0] byte_error, [2:1] tail_errors,
                                     // [34:3] error_count, [39:35] zero

   // Checker state mirrored from the block
   logic [ByteWidth-1:0]  prior_bytes [3];
   logic [CountWidth-1:0] running_errors;

   byte_row_type    byte_stream [$];
   utf8_result_type pending_results [$];

   int unsigned mismatches;
   int unsigned results_seen;
   int unsigned streams_sent;
   int unsigned flagged_bytes;
   int unsigned short_streams;
   int unsigned cycles;
   int unsigned stall_left;
   bit          quiet;

   utf8_stream_error_counter_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Decide whether one byte breaks the encoding rules given the three before it
   function automatic logic utf8_rule_broken(input logic [ByteWidth-1:0] cur,
                                             input logic [ByteWidth-1:0] back1,
                                             input logic [ByteWidth-1:0] back2,
                                             input logic [ByteWidth-1:0] back3);
      logic bad;
      bad = ((cur[7:6] == 2'b10) !=
             ((back1 >= Lead2Low) || (back2 >= Lead3Low) || (back3 >= Lead4Low)));
      case (back1)
         Lead3Low: if (cur < AfterE0Min) bad = 1'b1;
         SurrLead: if (cur > AfterEDMax) bad = 1'b1;
         Lead4Low: if (cur < AfterF0Min) bad = 1'b1;
         TopLead:  if (cur > AfterF4Max) bad = 1'b1;
         default: ;
      endcase
      if (cur == Lead2Low || cur == OverLongHi || cur >= BadLeadLow) bad = 1'b1;
      return bad;
   endfunction

   // Advance the mirrored history and count by one byte; return its result
   function automatic utf8_result_type advance_utf8_check(input logic [ByteWidth-1:0] cur,
                                                          input logic eos);
      utf8_result_type res;
      logic [ByteWidth-1:0] shifted;
      int k;
      res = '0;
      res.byte_error = utf8_rule_broken(cur, prior_bytes[0], prior_bytes[1], prior_bytes[2]);
      if (res.byte_error && running_errors != CountMax) running_errors++;
      prior_bytes[2] = prior_bytes[1];
      prior_bytes[1] = prior_bytes[0];
      prior_bytes[0] = cur;
      // pad the stream with zero bytes to expose missing continuations
      if (eos) begin
         for (k = 0; k < 3; k++) begin
            shifted = 8'h00;
            if (utf8_rule_broken(shifted, prior_bytes[0], prior_bytes[1], prior_bytes[2]))
            begin
               res.tail_errors++;
               if (running_errors != CountMax) running_errors++;
            end
            prior_bytes[2] = prior_bytes[1];
            prior_bytes[1] = prior_bytes[0];
            prior_bytes[0] = shifted;
         end
      end
      res.error_count = running_errors;
      if (eos) begin
         prior_bytes = '{default: '0};
         running_errors = '0;
      end
      return res;
   endfunction

   function automatic void push_stream_byte(input logic [ByteWidth-1:0] value);
      byte_row_type row;
      row = '0;
      row.data = value;
      byte_stream.push_back(row);
   endfunction

   function automatic logic [ByteWidth-1:0] any_continuation();
      return 8'(($urandom_range(8'h80, 8'hBF)));
   endfunction

   // Build one stream of mostly well-formed characters, with noise, cut and
   // corrupted characters mixed in; mark its final byte
   function automatic void append_random_stream();
      int unsigned          target;
      int unsigned          emitted;
      int unsigned          flavor;
      int unsigned          keep;
      int unsigned          k;
      logic [ByteWidth-1:0] chr [$];
      target  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      emitted = 0;
      while (emitted < target) begin
         chr.delete();
         case ($urandom_range(1, 4))
            1: chr.push_back(8'($urandom_range(8'h00, 8'h7F)));
            2: begin
               chr.push_back(8'($urandom_range(8'hC2, 8'hDF)));
               chr.push_back(any_continuation());
            end
            3: begin
               chr.push_back(8'($urandom_range(8'hE0, 8'hEF)));
               if (chr[0] == Lead3Low) chr.push_back(8'($urandom_range(8'hA0, 8'hBF)));
               else if (chr[0] == SurrLead) chr.push_back(8'($urandom_range(8'h80, 8'h9F)));
               else chr.push_back(any_continuation());
               chr.push_back(any_continuation());
            end
            default: begin
               chr.push_back(8'($urandom_range(8'hF0, 8'hF4)));
               if (chr[0] == Lead4Low) chr.push_back(8'($urandom_range(8'h90, 8'hBF)));
               else if (chr[0] == TopLead) chr.push_back(8'($urandom_range(8'h80, 8'h8F)));
               else chr.push_back(any_continuation());
               chr.push_back(any_continuation());
               chr.push_back(any_continuation());
            end
         endcase
         flavor = $urandom_range(0, 19);
         keep   = chr.size();
         // noise byte, cut character or one corrupted byte
         if (flavor == 0) chr[0] = 8'($urandom_range(0, 255));
         else if (flavor == 1) keep = $urandom_range(1, chr.size());
         else if (flavor == 2) chr[$urandom_range(0, chr.size() - 1)] = 8'($urandom_range(0, 255));
         for (k = 0; k < keep; k++) push_stream_byte(chr[k]);
         emitted += keep;
      end
      byte_stream[byte_stream.size() - 1].eos = 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input logic [CountWidth-1:0] got,
                                  input logic [CountWidth-1:0] want);
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               results_seen, field, got, want);
      mismatches++;
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      utf8_result_type got;
      utf8_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            $display("MISMATCH result %0d arrived with nothing expected", results_seen);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (got.byte_error !== want.byte_error)
               report_mismatch("byte_error", CountWidth'(got.byte_error),
                               CountWidth'(want.byte_error));
            if (got.tail_errors !== want.tail_errors)
               report_mismatch("tail_errors", CountWidth'(got.tail_errors),
                               CountWidth'(want.tail_errors));
            if (got.error_count !== want.error_count)
               report_mismatch("error_count", got.error_count, want.error_count);
            if (got.pad !== want.pad)
               report_mismatch("padding", CountWidth'(got.pad), CountWidth'(want.pad));
         end
         results_seen++;
      end
   end

   // Stall the result channel in random bursts; hold it open near the end
   always @(posedge clock) begin
      if (reset || quiet) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_results.size());
         $display("utf8_stream_error_counter_core_tb NOT OK");
         $finish;
      end
   end

   initial begin
      byte_row_type    row;
      utf8_result_type want;
      int unsigned     i;
      mismatches     = 0;
      results_seen   = 0;
      streams_sent   = 0;
      flagged_bytes  = 0;
      short_streams  = 0;
      cycles         = 0;
      quiet          = 1'b0;
      prior_bytes    = '{default: '0};
      running_errors = '0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b1;

      // lay out the directed table followed by the random streams
      for (i = 0; i < DirRows; i++) byte_stream.push_back(DirectedRows[i]);
      while (byte_stream.size() < DirRows + RandomBytes) append_random_stream();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drive each byte, idling in bursts until the final stretch
      for (i = 0; i < byte_stream.size(); i++) begin
         row   = byte_stream[i];
         quiet = (i + QuietTail >= byte_stream.size());
         if (!quiet && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= row.data;
         req_tlast  <= row.eos;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         want = advance_utf8_check(row.data, row.eos);
         if (row.typed) begin
            want = '0;
            want.byte_error  = row.byte_error;
            want.tail_errors = row.tail_errors;
            want.error_count = row.error_count;
         end
         pending_results.push_back(want);
         if (want.byte_error) flagged_bytes++;
         if (want.tail_errors != 0) short_streams++;
         if (row.eos) streams_sent++;
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // drain outstanding results, then watch for strays
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d bytes in %0d streams checked, %0d bytes flagged,",
               byte_stream.size(), streams_sent, flagged_bytes);
      $display("%0d streams ended with continuations missing, %0d mismatches",
               short_streams, mismatches);
      if (mismatches == 0) begin
         $display("utf8_stream_error_counter_core_tb OK");
      end else begin
         $display("utf8_stream_error_counter_core_tb NOT OK");
      end
      $finish;
   end

endmodule

[utf8_stream_error_counter_core.f]
rtl/utf8ec_pkg.sv
rtl/utf8ec_check.sv
rtl/utf8_stream_error_counter_core.sv
tb/utf8_stream_error_counter_core_tb.sv
